/* src/ws2812pbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ws2812pbs_pkg
// Shared types and constants for the pixel bit serializer: configuration
// register set, register indexes, reset values and the pixel descriptor.
// ----------------------------------------------------------------------------
package ws2812pbs_pkg;

    localparam int BitsPerPixel = 24;
    localparam int FifoDepth    = 2;
    localparam int FifoPtrW     = $clog2(FifoDepth);
    localparam int FifoCntW     = $clog2(FifoDepth + 1);

    localparam logic [5:0] MAX_GAP_LEN    = 6'd40;
    localparam logic [5:0] LAST_DATA_POS  = 6'd23;
    localparam logic [5:0] DATA_POS_END   = 6'd24;

    // register indexes
    localparam logic [2:0] CFG_LED_COUNT   = 3'd0;
    localparam logic [2:0] CFG_COLOR_ORDER = 3'd1;
    localparam logic [2:0] CFG_ONE_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_ZERO_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_GAP_LEN     = 3'd4;

    // reset values
    localparam logic [15:0] RST_LED_COUNT   = 16'd1;
    localparam logic [7:0]  RST_COLOR_ORDER = 8'h42;
    localparam logic [7:0]  RST_ONE_WIDTH   = 8'd20;
    localparam logic [7:0]  RST_ZERO_WIDTH  = 8'd10;
    localparam logic [5:0]  RST_GAP_LEN     = 6'd40;

    typedef struct packed {
        logic [15:0] led_count;
        logic [7:0]  color_order;
        logic [7:0]  one_width;
        logic [7:0]  zero_width;
        logic [5:0]  gap_len;
    } cfg_t;

    typedef struct packed {
        logic [23:0] wire_bits;
        logic [5:0]  gap;
        logic        ends_frame;
    } desc_t;

endpackage

/* src/ws2812pbs_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ws2812pbs_front
// Accepts colors, reorders bytes into wire order, tracks the pixel count
// and builds one descriptor per pixel for the queue.
// ----------------------------------------------------------------------------
module ws2812pbs_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [23:0]          color,
    output logic                      full,
    input  wire ws2812pbs_pkg::cfg_t  cfg,
    input  wire logic                 q_full,
    output logic                      q_push,
    output ws2812pbs_pkg::desc_t      q_desc
);

    logic [15:0] pixels_sent_reg;
    logic [15:0] pixels_sent_next;
    logic [15:0] count;
    logic        ends_frame;
    logic [23:0] wire_bits;
    logic [5:0]  gap;

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        logic [7:0] byte_v;
        logic [1:0] rpos;
        logic [1:0] gpos;
        logic [1:0] bpos;
        rpos      = cfg.color_order[7:6];
        gpos      = cfg.color_order[4:3];
        bpos      = cfg.color_order[1:0];
        wire_bits = '0;
        for (int s = 0; s < 3; s++)
        begin
            byte_v = '0;
            if (rpos == 2'(s))
            begin
                byte_v = color[23:16];
            end
            if (gpos == 2'(s))
            begin
                byte_v = color[15:8];
            end
            if (bpos == 2'(s))
            begin
                byte_v = color[7:0];
            end
            wire_bits[(2 - s) * 8 +: 8] = byte_v;
        end
    end

    assign count      = (cfg.led_count == '0) ? 16'd1 : cfg.led_count;
    assign ends_frame = ({1'b0, pixels_sent_reg} + 17'd1) >= {1'b0, count};
    assign gap        = !ends_frame ? 6'd0 :
                        (cfg.gap_len > ws2812pbs_pkg::MAX_GAP_LEN) ?
                        ws2812pbs_pkg::MAX_GAP_LEN : cfg.gap_len;

    assign q_desc.wire_bits  = wire_bits;
    assign q_desc.gap        = gap;
    assign q_desc.ends_frame = ends_frame;

    always_comb
    begin
        pixels_sent_next = pixels_sent_reg;
        if (q_push)
        begin
            pixels_sent_next = ends_frame ? 16'd0 : pixels_sent_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_sent_reg <= '0;
        end
        else
        begin
            pixels_sent_reg <= pixels_sent_next;
        end
    end

endmodule
`default_nettype wire

/* src/ws2812pbs_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ws2812pbs_fifo
// Short descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module ws2812pbs_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr,
    input  wire ws2812pbs_pkg::desc_t wr_desc,
    output logic                      q_full,
    input  wire logic                 rd,
    output ws2812pbs_pkg::desc_t      rd_desc,
    output logic                      q_empty
);

    localparam int PtrW = ws2812pbs_pkg::FifoPtrW;
    localparam int CntW = ws2812pbs_pkg::FifoCntW;

    ws2812pbs_pkg::desc_t mem_reg [ws2812pbs_pkg::FifoDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    logic            do_wr;
    logic            do_rd;

    assign q_full  = cnt_reg == CntW'(ws2812pbs_pkg::FifoDepth);
    assign q_empty = cnt_reg == '0;
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_desc = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(ws2812pbs_pkg::FifoDepth - 1)) ?
                          '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(ws2812pbs_pkg::FifoDepth - 1)) ?
                          '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CntW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule
`default_nettype wire

/* src/ws2812pbs_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ws2812pbs_back
// Walks the head descriptor one bit period per cycle, when not stalled:
// 24 data pulses, then any reset gap, into a registered result stage.
// ----------------------------------------------------------------------------
module ws2812pbs_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ws2812pbs_pkg::cfg_t  cfg,
    input  wire logic                 q_empty,
    input  wire ws2812pbs_pkg::desc_t q_desc,
    output logic                      q_pop,
    output logic [7:0]                pulse_width,
    output logic                      is_reset_bit,
    output logic                      frame_end,
    output logic                      last,
    output logic                      empty,
    input  wire logic                 pop
);

    logic [5:0] pos_reg;
    logic [5:0] pos_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] width_reg;
    logic       rst_bit_reg;
    logic       frame_end_reg;
    logic       last_reg;
    logic       emit;
    logic       last_res;
    logic       in_data;
    logic [4:0] bit_idx;
    logic       data_bit;
    logic [7:0] width_val;

    assign emit     = !q_empty && (!out_valid_reg || pop);
    assign last_res = pos_reg == (ws2812pbs_pkg::LAST_DATA_POS + q_desc.gap);
    assign in_data  = pos_reg < ws2812pbs_pkg::DATA_POS_END;
    assign bit_idx  = in_data ? (5'd23 - pos_reg[4:0]) : 5'd0;
    assign data_bit = q_desc.wire_bits[bit_idx];
    assign width_val = !in_data ? 8'd0 :
                       data_bit ? cfg.one_width : cfg.zero_width;
    assign q_pop    = emit && last_res;

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            pos_next       = last_res ? 6'd0 : pos_reg + 6'd1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            width_reg     <= width_val;
            rst_bit_reg   <= !in_data;
            frame_end_reg <= last_res && q_desc.ends_frame;
            last_reg      <= last_res;
        end
    end

    assign pulse_width  = width_reg;
    assign is_reset_bit = rst_bit_reg;
    assign frame_end    = frame_end_reg;
    assign last         = last_reg;
    assign empty        = !out_valid_reg;

    // mid-pixel implies a descriptor at the queue head
    a_pos_has_desc: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != 6'd0) |-> !q_empty)
        else $error("bit position advanced without a descriptor");

    // last period of a pixel rewinds the position
    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_res) |=> (pos_reg == 6'd0))
        else $error("position not rewound after last period");

    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_end_reg) |-> last_reg)
        else $error("frame end on a result that is not last");

    a_reset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rst_bit_reg) |-> (width_reg == 8'd0))
        else $error("reset period with nonzero pulse width");

endmodule
`default_nettype wire

/* src/ws2812_pixel_bit_serializer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ws2812_pixel_bit_serializer_core
// Turns 24-bit colors into per-bit pulse widths in wire byte order, with a
// reset gap after the final pixel of each frame.
// ----------------------------------------------------------------------------
// the first result of a pixel passes the descriptor queue and then the result register
// the back serializer gives one result per cycle while not stalled; each pixel
//   makes 24 results, or 24 plus the reset gap (at most 40) at the end of a frame
// a two-entry descriptor queue lets the next pixel be taken while one plays
// reset: registers return to their defaults, pixel count zero, queues empty
module ws2812_pixel_bit_serializer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic [23:0] color,
    output logic             full,
    output logic [7:0]       pulse_width,
    output logic             is_reset_bit,
    output logic             frame_end,
    output logic             last,
    output logic             empty,
    input  wire logic        pop,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [15:0] wr_data
);

    ws2812pbs_pkg::cfg_t  cfg_reg;
    ws2812pbs_pkg::cfg_t  cfg_next;
    ws2812pbs_pkg::desc_t f_desc;
    ws2812pbs_pkg::desc_t h_desc;
    logic                 f_push;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                ws2812pbs_pkg::CFG_LED_COUNT:   cfg_next.led_count   = wr_data;
                ws2812pbs_pkg::CFG_COLOR_ORDER: cfg_next.color_order = wr_data[7:0];
                ws2812pbs_pkg::CFG_ONE_WIDTH:   cfg_next.one_width   = wr_data[7:0];
                ws2812pbs_pkg::CFG_ZERO_WIDTH:  cfg_next.zero_width  = wr_data[7:0];
                ws2812pbs_pkg::CFG_GAP_LEN:     cfg_next.gap_len     = wr_data[5:0];
                default:                        cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.led_count   <= ws2812pbs_pkg::RST_LED_COUNT;
            cfg_reg.color_order <= ws2812pbs_pkg::RST_COLOR_ORDER;
            cfg_reg.one_width   <= ws2812pbs_pkg::RST_ONE_WIDTH;
            cfg_reg.zero_width  <= ws2812pbs_pkg::RST_ZERO_WIDTH;
            cfg_reg.gap_len     <= ws2812pbs_pkg::RST_GAP_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ws2812pbs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .color  (color),
        .full   (full),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (f_push),
        .q_desc (f_desc)
    );

    ws2812pbs_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_push),
        .wr_desc (f_desc),
        .q_full  (q_full),
        .rd      (q_pop),
        .rd_desc (h_desc),
        .q_empty (q_empty)
    );

    ws2812pbs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_desc       (h_desc),
        .q_pop        (q_pop),
        .pulse_width  (pulse_width),
        .is_reset_bit (is_reset_bit),
        .frame_end    (frame_end),
        .last         (last),
        .empty        (empty),
        .pop          (pop)
    );

endmodule
`default_nettype wire

/* test/tb_ws2812_pixel_bit_serializer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ws2812_pixel_bit_serializer_core
// Self-checking bench for the pixel bit serializer. A queue-fed driver pushes
// colors while an in-bench encoder predicts every pulse of each pixel: wire
// byte order, pulse widths, reset gap and frame marks. A monitor pops results
// and compares them field by field. Directed corner cases, including a long
// receiver hold-off, come first, then random register settings with random
// colors and random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_ws2812_pixel_bit_serializer_core;

    typedef struct {
        logic [7:0] width;
        logic       gap_bit;
        logic       frame_end;
        logic       last_of_pixel;
    } pulse_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [23:0] color = '0;
    logic        full;
    logic [7:0]  pulse_width;
    logic        is_reset_bit;
    logic        frame_end;
    logic        last;
    logic        empty;
    logic        pop = 1'b0;
    logic        wr_en = 1'b0;
    logic [2:0]  wr_index = '0;
    logic [15:0] wr_data = '0;

    logic [23:0]         color_q[$];
    pulse_t              pulse_q[$];
    ws2812pbs_pkg::cfg_t model_cfg;
    logic [15:0]         frame_pixels;
    logic                color_taken = 1'b0;
    logic                idle_on = 1'b1;
    int                  err_count = 0;
    int                  stall_req = 0;
    int                  stall_seen = 0;
    int                  hold_left = 0;

    ws2812_pixel_bit_serializer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .color        (color),
        .full         (full),
        .pulse_width  (pulse_width),
        .is_reset_bit (is_reset_bit),
        .frame_end    (frame_end),
        .last         (last),
        .empty        (empty),
        .pop          (pop),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [15:0] got_v,
                                   input logic [15:0] want_v);
        err_count++;
        $display("mismatch at %0t ns: %s got %0d expected %0d",
                 $time, what, got_v, want_v);
    endtask

    // expected pulses of one pixel, appended in wire order
    function automatic void encode_pixel(input logic [23:0] c);
        logic [1:0]  rpos;
        logic [1:0]  gpos;
        logic [1:0]  bpos;
        logic [16:0] frame_len;
        logic [5:0]  gap;
        logic        ends;
        logic [7:0]  wire_byte;
        pulse_t      p;
        pulse_t      run[$];
        rpos = model_cfg.color_order[7:6];
        gpos = model_cfg.color_order[4:3];
        bpos = model_cfg.color_order[1:0];
        frame_len = (model_cfg.led_count == 16'd0) ? 17'd1 : {1'b0, model_cfg.led_count};
        gap = (model_cfg.gap_len > ws2812pbs_pkg::MAX_GAP_LEN) ?
              ws2812pbs_pkg::MAX_GAP_LEN : model_cfg.gap_len;
        ends = ({1'b0, frame_pixels} + 17'd1) >= frame_len;
        for (int s = 0; s < 3; s++)
        begin
            wire_byte = 8'd0;
            if (rpos == s) wire_byte = c[23:16];
            if (gpos == s) wire_byte = c[15:8];
            if (bpos == s) wire_byte = c[7:0];
            for (int b = 7; b >= 0; b--)
            begin
                p.width = wire_byte[b] ? model_cfg.one_width : model_cfg.zero_width;
                p.gap_bit = 1'b0;
                p.frame_end = 1'b0;
                p.last_of_pixel = 1'b0;
                run.push_back(p);
            end
        end
        if (ends)
        begin
            for (int i = 0; i < gap; i++)
            begin
                p.width = 8'd0;
                p.gap_bit = 1'b1;
                p.frame_end = 1'b0;
                p.last_of_pixel = 1'b0;
                run.push_back(p);
            end
            run[run.size() - 1].frame_end = 1'b1;
            frame_pixels = 16'd0;
        end
        else
        begin
            frame_pixels = frame_pixels + 16'd1;
        end
        run[run.size() - 1].last_of_pixel = 1'b1;
        foreach (run[i]) pulse_q.push_back(run[i]);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            ws2812pbs_pkg::CFG_LED_COUNT:   model_cfg.led_count = val;
            ws2812pbs_pkg::CFG_COLOR_ORDER: model_cfg.color_order = val[7:0];
            ws2812pbs_pkg::CFG_ONE_WIDTH:   model_cfg.one_width = val[7:0];
            ws2812pbs_pkg::CFG_ZERO_WIDTH:  model_cfg.zero_width = val[7:0];
            ws2812pbs_pkg::CFG_GAP_LEN:     model_cfg.gap_len = val[5:0];
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] leds, input logic [15:0] order,
                              input logic [15:0] one_w, input logic [15:0] zero_w,
                              input logic [15:0] gap_bits);
        write_reg(ws2812pbs_pkg::CFG_LED_COUNT, leds);
        write_reg(ws2812pbs_pkg::CFG_COLOR_ORDER, order);
        write_reg(ws2812pbs_pkg::CFG_ONE_WIDTH, one_w);
        write_reg(ws2812pbs_pkg::CFG_ZERO_WIDTH, zero_w);
        write_reg(ws2812pbs_pkg::CFG_GAP_LEN, gap_bits);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (color_q.size() != 0 || push || pulse_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // input side
    always @(negedge clk)
    begin
        if (!push || color_taken)
        begin
            if (color_q.size() != 0 && !(idle_on && $urandom_range(99) < 9))
            begin
                push <= 1'b1;
                color <= color_q.pop_front();
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // result side, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (stall_req != stall_seen)
        begin
            stall_seen = stall_req;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= !(idle_on && $urandom_range(99) < 9);
        end
    end

    // predict on each input transfer, check on each result transfer
    always @(posedge clk)
    begin
        pulse_t want;
        color_taken = rst_n && push && !full;
        if (color_taken)
            encode_pixel(color);
        if (rst_n && pop && !empty)
        begin
            if (pulse_q.size() == 0)
            begin
                report_mismatch("result with none expected, pulse_width",
                                pulse_width, 16'd0);
            end
            else
            begin
                want = pulse_q.pop_front();
                if (pulse_width !== want.width)
                    report_mismatch("pulse_width", pulse_width, want.width);
                if (is_reset_bit !== want.gap_bit)
                    report_mismatch("is_reset_bit", is_reset_bit, want.gap_bit);
                if (frame_end !== want.frame_end)
                    report_mismatch("frame_end", frame_end, want.frame_end);
                if (last !== want.last_of_pixel)
                    report_mismatch("last", last, want.last_of_pixel);
            end
        end
    end

    initial
    begin
        int unsigned r;
        logic [15:0] leds;
        logic [15:0] gap_bits;
        logic [23:0] c;
        model_cfg.led_count = ws2812pbs_pkg::RST_LED_COUNT;
        model_cfg.color_order = ws2812pbs_pkg::RST_COLOR_ORDER;
        model_cfg.one_width = ws2812pbs_pkg::RST_ONE_WIDTH;
        model_cfg.zero_width = ws2812pbs_pkg::RST_ZERO_WIDTH;
        model_cfg.gap_len = ws2812pbs_pkg::RST_GAP_LEN;
        frame_pixels = 16'd0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults: every pixel ends a frame with the full reset gap
        color_q.push_back(24'h000000);
        color_q.push_back(24'hFFFFFF);
        color_q.push_back(24'hA5C33C);
        wait_drained();

        // straight order, widest one, narrowest zero, no gap
        set_config(16'd3, 16'h000A, 16'd255, 16'd0, 16'd0);
        color_q.push_back(24'h800001);
        color_q.push_back(24'h7F00FE);
        color_q.push_back(24'h123456);
        color_q.push_back(24'hFEDCBA);
        wait_drained();

        // all colors on slot 0 so blue wins, zero count, gap saturated
        set_config(16'd0, 16'hFF24, 16'hAB00, 16'd255, 16'hFFFF);
        color_q.push_back(24'h11AA55);
        color_q.push_back(24'hFF00FF);
        wait_drained();

        // green over red on slot 1, blue unsent, count lowered mid-frame
        set_config(16'd5, 16'h004B, 16'd1, 16'd254, 16'd41);
        color_q.push_back(24'hC3A55A);
        color_q.push_back(24'h0F0FF0);
        wait_drained();
        write_reg(ws2812pbs_pkg::CFG_LED_COUNT, 16'd1);
        color_q.push_back(24'h5AA5C3);
        wait_drained();

        // no slot claimed, longest frame
        set_config(16'hFFFF, 16'h00FF, 16'd77, 16'd33, 16'd1);
        color_q.push_back(24'hFFFFFF);
        color_q.push_back(24'h3C3C3C);
        wait_drained();

        // receiver holds off while the sender keeps offering
        set_config(16'd2, 16'h0042, 16'd20, 16'd10, 16'd3);
        stall_req++;
        for (int i = 0; i < 12; i++) color_q.push_back(24'($urandom()));
        wait_drained();

        for (int ph = 0; ph < 7; ph++)
        begin
            r = $urandom_range(9);
            if (r == 0) leds = 16'd0;
            else if (r == 1) leds = 16'($urandom());
            else leds = 16'($urandom_range(1, 6));
            if ($urandom_range(3) == 0) gap_bits = 16'($urandom());
            else gap_bits = 16'($urandom_range(0, 8));
            set_config(leds, 16'($urandom()), 16'($urandom()), 16'($urandom()), gap_bits);
            idle_on = (ph != 3);
            for (int half = 0; half < 2; half++)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    r = $urandom_range(9);
                    if (r == 0) c = 24'h000000;
                    else if (r == 1) c = 24'hFFFFFF;
                    else c = 24'($urandom());
                    color_q.push_back(c);
                end
                if (ph == 2 && half == 0) wait_drained();
            end
            wait_drained();
        end
        idle_on = 1'b1;

        repeat (30) @(negedge clk);
        if (pulse_q.size() != 0)
            report_mismatch("results never delivered", 16'(pulse_q.size()), 16'd0);
        if (err_count == 0)
            $display("tb_ws2812_pixel_bit_serializer_core: done, clean");
        else
            $display("tb_ws2812_pixel_bit_serializer_core: done, errors");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("tb_ws2812_pixel_bit_serializer_core: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
src/ws2812pbs_pkg.sv
src/ws2812pbs_front.sv
src/ws2812pbs_fifo.sv
src/ws2812pbs_back.sv
src/ws2812_pixel_bit_serializer_core.sv
test/tb_ws2812_pixel_bit_serializer_core.sv
